// ===== design/avota_pkg.sv =====
// ----------------------------------------------------------------------------
// AVO trend attribute package
// Shared widths, register indexes, attribute kinds and class code constants
// for the AVO trend attribute unit.
// ----------------------------------------------------------------------------
`default_nettype none

package avota_pkg;

    // Field widths.
    localparam int SAMPLE_W = 16;   // Q3.12 intercept and gradient
    localparam int TRIG_W   = 16;   // Q1.14 sine and cosine
    localparam int TAN_W    = 24;   // Q9.14 tangent
    localparam int RESULT_W = 20;   // Q7.12 attribute value
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;

    // Fraction bits dropped when an exact 2^-26 sum becomes Q7.12.
    localparam int ROUND_SHIFT = 14;

    // Attribute selected by the kind register.
    typedef enum logic [1:0] {
        ATTR_FLUID    = 2'd0,
        ATTR_LITHO    = 2'd1,
        ATTR_POLARITY = 2'd2,
        ATTR_CLASS    = 2'd3
    } attr_kind_t;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_KIND    = 3'd0,
        REG_SINE    = 3'd1,
        REG_COSINE  = 3'd2,
        REG_TANGENT = 3'd3,
        REG_OFFSET  = 3'd4
    } cfg_index_t;

    // Reset value of the cosine register, 1.0 in Q1.14.
    localparam logic signed [TRIG_W-1:0] COSINE_RESET = 16'sd16384;

    // AVO class codes, scaled by 4096 to sit in the Q7.12 result.
    localparam logic signed [RESULT_W-1:0] CLASS_POS_1 = 20'sd4096;
    localparam logic signed [RESULT_W-1:0] CLASS_NEG_1 = -20'sd4096;
    localparam logic signed [RESULT_W-1:0] CLASS_POS_3 = 20'sd12288;
    localparam logic signed [RESULT_W-1:0] CLASS_NEG_3 = -20'sd12288;
    localparam logic signed [RESULT_W-1:0] CLASS_POS_4 = 20'sd16384;
    localparam logic signed [RESULT_W-1:0] CLASS_NEG_4 = -20'sd16384;

    // Saturation limits of the Q7.12 result.
    localparam logic signed [RESULT_W-1:0] RESULT_MAX = 20'sd524287;
    localparam logic signed [RESULT_W-1:0] RESULT_MIN = -20'sd524288;

    // Half of one result LSB in exact 2^-26 units.
    localparam int ROUND_HALF = 8192;

endpackage : avota_pkg

`default_nettype wire

// ===== design/avo_trend_attribute_unit_top.sv =====
// ----------------------------------------------------------------------------
// AVO trend attribute unit
// Computes fluid factor, lithology factor, polarity-signed lithology factor
// or AVO class for each intercept/gradient sample against a configured trend.
// ----------------------------------------------------------------------------
//
// The unit takes one intercept/gradient sample pair per transfer and returns
// one attribute per transfer, in order. A sample passes through the input,
// product and result registers before the output valid rises. It sustains
// one transfer per cycle while results are taken downstream: the three-stage
// pipeline (input register, product register, result register) advances
// whenever the stage ahead of it is empty or moving, so a new sample is taken
// while a finished result waits for the downstream side as long as an earlier
// stage is still empty. Only when all three stages are full and the result is
// not taken does the input ready drop, in that same cycle. The longest logic
// path sits in the product stage, which runs five multipliers of at most 16 by
// 24 bits in parallel. The trend line is G = offset - I * tan(phi);
// sine, cosine, tangent and offset come from the configuration channel, which
// should be written only while the pipeline is empty. A sample with either
// validity flag cleared yields a zero value with the null flag set.
`default_nettype none

module avo_trend_attribute_unit_top
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,

    // Sample input. tdata: intercept_sample [15:0], gradient_sample [31:16].
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  wire logic [31:0]                          s_axis_tdata,
    // tuser: intercept_valid [0], gradient_valid [1].
    input  wire logic [1:0]                           s_axis_tuser,

    // Result output. tdata: attribute_value [19:0], zero padding [23:20].
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    output logic [23:0]                               m_axis_tdata,
    // tuser: result_null [0].
    output logic                                      m_axis_tuser,

    // Configuration write channel.
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [avota_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [avota_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import avota_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    attr_kind_t                  kind_reg;
    logic signed [TRIG_W-1:0]    sine_reg;
    logic signed [TRIG_W-1:0]    cosine_reg;
    logic signed [TAN_W-1:0]     tangent_reg;
    logic signed [SAMPLE_W-1:0]  offset_reg;

    // The register file always takes a write in the cycle it is offered.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg    <= ATTR_FLUID;
            sine_reg    <= '0;
            cosine_reg  <= COSINE_RESET;
            tangent_reg <= '0;
            offset_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_addr))
                REG_KIND:    kind_reg    <= attr_kind_t'(cfg_data[1:0]);
                REG_SINE:    sine_reg    <= cfg_data[TRIG_W-1:0];
                REG_COSINE:  cosine_reg  <= cfg_data[TRIG_W-1:0];
                REG_TANGENT: tangent_reg <= cfg_data[TAN_W-1:0];
                REG_OFFSET:  offset_reg  <= cfg_data[SAMPLE_W-1:0];
                default:     ; // Indexes beyond the register list are ignored.
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control
    // ------------------------------------------------------------------
    logic in_valid_reg;
    logic prod_valid_reg;
    logic out_valid_reg;
    logic out_advance;
    logic prod_advance;
    logic in_advance;

    // Each stage loads when it is empty or its content moves on.
    assign out_advance   = !out_valid_reg || m_axis_tready;
    assign prod_advance  = !prod_valid_reg || out_advance;
    assign in_advance    = !in_valid_reg || prod_advance;
    assign s_axis_tready = in_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_advance)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (prod_advance)
            begin
                prod_valid_reg <= in_valid_reg;
            end
            if (out_advance)
            begin
                out_valid_reg <= prod_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    logic signed [SAMPLE_W-1:0] icpt_reg;
    logic signed [SAMPLE_W-1:0] grad_reg;
    logic                       ok_reg;

    always_ff @(posedge clk)
    begin
        if (in_advance && s_axis_tvalid)
        begin
            icpt_reg <= s_axis_tdata[SAMPLE_W-1:0];
            grad_reg <= s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
            ok_reg   <= s_axis_tuser[0] && s_axis_tuser[1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: products, exact in 2^-26 units
    // ------------------------------------------------------------------
    logic signed [SAMPLE_W:0]             gdiff;
    logic signed [SAMPLE_W+TRIG_W-1:0]    p_is_next;
    logic signed [SAMPLE_W+TRIG_W:0]      p_gc_next;
    logic signed [SAMPLE_W+TRIG_W-1:0]    p_ic_next;
    logic signed [SAMPLE_W+TRIG_W:0]      p_gs_next;
    logic signed [SAMPLE_W+TAN_W-1:0]     p_it_next;

    logic signed [SAMPLE_W+TRIG_W-1:0]    p_is_reg;
    logic signed [SAMPLE_W+TRIG_W:0]      p_gc_reg;
    logic signed [SAMPLE_W+TRIG_W-1:0]    p_ic_reg;
    logic signed [SAMPLE_W+TRIG_W:0]      p_gs_reg;
    logic signed [SAMPLE_W+TAN_W-1:0]     p_it_reg;
    logic signed [SAMPLE_W-1:0]           icpt_p_reg;
    logic signed [SAMPLE_W-1:0]           grad_p_reg;
    logic                                 ok_p_reg;

    always_comb
    begin
        gdiff     = (SAMPLE_W+1)'(grad_reg) - (SAMPLE_W+1)'(offset_reg);
        p_is_next = icpt_reg * sine_reg;
        p_gc_next = gdiff * cosine_reg;
        p_ic_next = icpt_reg * cosine_reg;
        p_gs_next = gdiff * sine_reg;
        p_it_next = icpt_reg * tangent_reg;
    end

    always_ff @(posedge clk)
    begin
        if (prod_advance && in_valid_reg)
        begin
            p_is_reg   <= p_is_next;
            p_gc_reg   <= p_gc_next;
            p_ic_reg   <= p_ic_next;
            p_gs_reg   <= p_gs_next;
            p_it_reg   <= p_it_next;
            icpt_p_reg <= icpt_reg;
            grad_p_reg <= grad_reg;
            ok_p_reg   <= ok_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: sums, trend compare, rounding and saturation
    // ------------------------------------------------------------------
    localparam int SUM_W   = SAMPLE_W + TRIG_W + 3;  // room for the negation
    localparam int TREND_W = SAMPLE_W + TAN_W + 1;
    localparam int QUOT_W  = SUM_W + 1 - ROUND_SHIFT;

    logic signed [SUM_W-1:0]    fluid_sum;
    logic signed [SUM_W-1:0]    litho_sum;
    logic signed [SUM_W-1:0]    pick_sum;
    logic signed [SUM_W:0]      biased;
    logic signed [QUOT_W-1:0]   quot;
    logic signed [RESULT_W-1:0] rounded;
    logic signed [TREND_W-1:0]  trend26;
    logic signed [TREND_W-1:0]  grad26;
    logic                       above;
    logic                       below;
    logic                       same_sign;
    logic signed [RESULT_W-1:0] class_code;
    logic signed [RESULT_W-1:0] value_next;
    logic                       null_next;
    logic signed [RESULT_W-1:0] value_reg;
    logic                       null_reg;

    always_comb
    begin
        fluid_sum = SUM_W'(p_is_reg) + SUM_W'(p_gc_reg);
        litho_sum = SUM_W'(p_ic_reg) - SUM_W'(p_gs_reg);

        // Trend line and sample gradient, both scaled to 2^-26.
        trend26 = TREND_W'($signed({offset_reg, 14'd0})) - TREND_W'(p_it_reg);
        grad26  = TREND_W'($signed({grad_p_reg, 14'd0}));
        above   = grad26 > trend26;
        below   = grad26 < trend26;

        // Polarity flips the lithology sum for samples under the trend.
        priority if (kind_reg == ATTR_FLUID)
        begin
            pick_sum = fluid_sum;
        end
        else if (kind_reg == ATTR_POLARITY && below)
        begin
            pick_sum = -litho_sum;
        end
        else
        begin
            pick_sum = litho_sum;
        end

        // Round half up: add half an LSB, then floor through the shift.
        biased = (SUM_W+1)'(pick_sum) + (SUM_W+1)'(ROUND_HALF);
        quot   = biased[SUM_W:ROUND_SHIFT];
        if (quot > QUOT_W'(RESULT_MAX))
        begin
            rounded = RESULT_MAX;
        end
        else if (quot < QUOT_W'(RESULT_MIN))
        begin
            rounded = RESULT_MIN;
        end
        else
        begin
            rounded = quot[RESULT_W-1:0];
        end

        // Zero counts as both signs when grouping intercept and gradient.
        same_sign = (!icpt_p_reg[SAMPLE_W-1] && !grad_p_reg[SAMPLE_W-1]) ||
                    (icpt_p_reg <= 0 && grad_p_reg <= 0);
        priority if (same_sign)
        begin
            class_code = above ? CLASS_POS_3 : CLASS_NEG_3;
        end
        else if (grad_p_reg > 0)
        begin
            class_code = above ? CLASS_POS_1 : CLASS_NEG_4;
        end
        else
        begin
            class_code = above ? CLASS_POS_4 : CLASS_NEG_1;
        end

        null_next = !ok_p_reg;
        if (!ok_p_reg)
        begin
            value_next = '0;
        end
        else if (kind_reg == ATTR_CLASS)
        begin
            value_next = class_code;
        end
        else
        begin
            value_next = rounded;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_advance && prod_valid_reg)
        begin
            value_reg <= value_next;
            null_reg  <= null_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, value_reg};
    assign m_axis_tuser  = null_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    // A null result always carries a zero attribute value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 24'd0)
        else $error("null result with nonzero attribute value");

    // An empty output register never blocks the input side.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_axis_tready)
        else $error("input stalled while the output register is empty");

    // A stalled product stage behind a full input stage must hold the input closed.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && prod_valid_reg && !out_advance |-> !s_axis_tready)
        else $error("input accepted while the pipeline is full and stalled");

    // A stalled result holds its place for the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |=> out_valid_reg && $stable(value_reg))
        else $error("stalled result lost or changed");
`endif

endmodule : avo_trend_attribute_unit_top

`default_nettype wire
